// ===== hw/rtl/aabb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package aabb_pkg;

  localparam int MaxBoxes = 64;
  localparam int IdxW     = (MaxBoxes > 1) ? $clog2(MaxBoxes) : 1;
  localparam int CntW     = $clog2(MaxBoxes + 1);

  localparam int CoordW   = 32;
  localparam int FrameW   = 16;
  localparam int KitW     = 8;
  localparam int CountW   = 7;
  localparam int EntryIdxW = 6;
  localparam int ActionW  = 2;

  typedef enum logic [ActionW-1:0] {
    ACT_WRITE   = 2'd0,
    ACT_OVERLAP = 2'd1,
    ACT_SLIDE   = 2'd2
  } action_e;

  // Input word, entry_index in the lowest bits.
  typedef struct packed {
    logic                     pad;
    logic [FrameW-1:0]        frame_high;
    logic [FrameW-1:0]        frame_low;
    logic                     solid_flag;
    logic [KitW-1:0]          kit_code;
    logic signed [CoordW-1:0] vec_b_z;
    logic signed [CoordW-1:0] vec_b_y;
    logic signed [CoordW-1:0] vec_b_x;
    logic signed [CoordW-1:0] vec_a_z;
    logic signed [CoordW-1:0] vec_a_y;
    logic signed [CoordW-1:0] vec_a_x;
    logic [EntryIdxW-1:0]     entry_index;
  } in_word_t;

  typedef struct packed {
    logic signed [CoordW-1:0] pos_z;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_x;
    logic                     blocked;
    logic [KitW-1:0]          entered_kit;
    logic [CountW-1:0]        hit_count;
  } out_word_t;

  localparam int InWordW  = $bits(in_word_t);
  localparam int OutWordW = $bits(out_word_t);

  typedef struct packed {
    logic [FrameW-1:0]        frame_last;
    logic [FrameW-1:0]        frame_first;
    logic                     solid;
    logic [KitW-1:0]          kit;
    logic signed [CoordW-1:0] max_z;
    logic signed [CoordW-1:0] max_y;
    logic signed [CoordW-1:0] max_x;
    logic signed [CoordW-1:0] min_z;
    logic signed [CoordW-1:0] min_y;
    logic signed [CoordW-1:0] min_x;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  typedef struct packed {
    logic accept;
    logic walk;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic issue_left;
    logic in_flight;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/aabb_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module aabb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                          wdata_i,
  input  wire logic                                      re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                               rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/aabb_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module aabb_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire aabb_pkg::status_t status_i,
  output aabb_pkg::cmd_t         cmd_o
);
  import aabb_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StWalk = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    case (state_q)
      StIdle: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.accept = 1'b1;
          state_d      = status_i.is_query ? StWalk : StDone;
        end
      end
      StWalk: begin
        cmd_o.walk = 1'b1;
        if (!status_i.issue_left && !status_i.in_flight) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (status_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/aabb_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module aabb_dp (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic [aabb_pkg::InWordW-1:0]          s_axis_tdata,
  input  wire logic [aabb_pkg::ActionW-1:0]          s_axis_tuser,
  input  wire logic                                  cfg_we_i,
  input  wire logic [aabb_pkg::CountW-1:0]           cfg_wdata_i,
  input  wire aabb_pkg::cmd_t                        cmd_i,
  output aabb_pkg::status_t                          status_o,
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  output logic [aabb_pkg::OutWordW-1:0]              m_axis_tdata
);
  import aabb_pkg::*;

  function automatic logic signed [CoordW-1:0] sat_add(
    input logic signed [CoordW-1:0] a,
    input logic signed [CoordW-1:0] b
  );
    logic signed [CoordW:0] sum;
    logic signed [CoordW-1:0] res;
    sum = {a[CoordW-1], a} + {b[CoordW-1], b};
    if (sum[CoordW] != sum[CoordW-1]) begin
      res = sum[CoordW] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
    end else begin
      res = sum[CoordW-1:0];
    end
    return res;
  endfunction

  in_word_t                 in_w;
  logic [ActionW-1:0]       in_act;
  entry_t                   wr_entry;
  entry_t                   rd_entry;
  logic                     ram_we;
  logic                     ram_re;
  logic [IdxW-1:0]          ram_waddr;
  logic [IdxW-1:0]          ram_raddr;

  logic [ActionW-1:0]       act_q;
  logic signed [CoordW-1:0] pt_x_q, pt_y_q, pt_z_q;
  logic signed [CoordW-1:0] st_x_q, st_y_q, st_z_q;
  logic [FrameW-1:0]        frame_q;
  logic [CountW-1:0]        box_count_q;
  logic [CntW-1:0]          cnt_q;
  logic [CntW-1:0]          limit;
  logic [CntW-1:0]          hits_q;
  logic                     rd_vld_q;
  logic                     blocked_q;
  logic [KitW-1:0]          kit_q;
  logic                     m_valid_q;
  out_word_t                m_data_q;
  out_word_t                out_w;
  logic                     issue;
  logic                     in_box;
  logic                     hit;
  logic                     out_free;

  assign in_w   = in_word_t'(s_axis_tdata);
  assign in_act = s_axis_tuser;

  always_comb begin
    wr_entry.frame_last  = in_w.frame_high;
    wr_entry.frame_first = in_w.frame_low;
    wr_entry.solid       = in_w.solid_flag;
    wr_entry.kit         = in_w.kit_code;
    wr_entry.max_z       = in_w.vec_b_z;
    wr_entry.max_y       = in_w.vec_b_y;
    wr_entry.max_x       = in_w.vec_b_x;
    wr_entry.min_z       = in_w.vec_a_z;
    wr_entry.min_y       = in_w.vec_a_y;
    wr_entry.min_x       = in_w.vec_a_x;
  end

  assign ram_we    = cmd_i.accept && (in_act == ACT_WRITE) &&
                     (int'(in_w.entry_index) < MaxBoxes);
  assign ram_waddr = IdxW'(in_w.entry_index);
  assign limit     = (int'(box_count_q) > MaxBoxes) ? CntW'(MaxBoxes) : CntW'(box_count_q);
  assign issue     = cmd_i.walk && (cnt_q < limit);
  assign ram_re    = issue;
  assign ram_raddr = IdxW'(cnt_q);

  aabb_ram #(
    .Width(EntryW),
    .Depth(MaxBoxes)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(wr_entry),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(rd_entry)
  );

  assign in_box = ($signed(pt_x_q) >= $signed(rd_entry.min_x)) &&
                  ($signed(pt_x_q) <= $signed(rd_entry.max_x)) &&
                  ($signed(pt_y_q) >= $signed(rd_entry.min_y)) &&
                  ($signed(pt_y_q) <= $signed(rd_entry.max_y)) &&
                  ($signed(pt_z_q) >= $signed(rd_entry.min_z)) &&
                  ($signed(pt_z_q) <= $signed(rd_entry.max_z)) &&
                  (frame_q >= rd_entry.frame_first) &&
                  (frame_q <= rd_entry.frame_last);
  assign hit = rd_vld_q && in_box;

  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    status_o.is_query   = (in_act == ACT_OVERLAP) || (in_act == ACT_SLIDE);
    status_o.issue_left = cnt_q < limit;
    status_o.in_flight  = rd_vld_q;
    status_o.out_free   = out_free;
  end

  always_comb begin
    out_w             = '0;
    out_w.hit_count   = CountW'(hits_q);
    out_w.entered_kit = kit_q;
    out_w.blocked     = blocked_q;
    if (act_q == ACT_SLIDE) begin
      out_w.pos_x = blocked_q ? st_x_q : pt_x_q;
      out_w.pos_y = blocked_q ? st_y_q : pt_y_q;
      out_w.pos_z = blocked_q ? st_z_q : pt_z_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_count_q <= '0;
      act_q       <= '0;
      cnt_q       <= '0;
      hits_q      <= '0;
      rd_vld_q    <= 1'b0;
      blocked_q   <= 1'b0;
      kit_q       <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        box_count_q <= cfg_wdata_i;
      end
      rd_vld_q <= issue;
      if (cmd_i.accept) begin
        act_q     <= in_act;
        cnt_q     <= '0;
        hits_q    <= '0;
        blocked_q <= 1'b0;
        if (in_act == ACT_OVERLAP) begin
          kit_q <= '0;
        end
      end else begin
        if (issue) begin
          cnt_q <= cnt_q + 1'b1;
        end
        if (hit && (act_q == ACT_OVERLAP)) begin
          hits_q <= hits_q + 1'b1;
          kit_q  <= rd_entry.kit;
        end
        if (hit && (act_q == ACT_SLIDE) && rd_entry.solid) begin
          blocked_q <= 1'b1;
        end
      end
      if (cmd_i.load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      frame_q <= in_w.frame_low;
      st_x_q  <= in_w.vec_a_x;
      st_y_q  <= in_w.vec_a_y;
      st_z_q  <= in_w.vec_a_z;
      if (in_act == ACT_SLIDE) begin
        pt_x_q <= sat_add(in_w.vec_a_x, in_w.vec_b_x);
        pt_y_q <= sat_add(in_w.vec_a_y, in_w.vec_b_y);
        pt_z_q <= sat_add(in_w.vec_a_z, in_w.vec_b_z);
      end else begin
        pt_x_q <= in_w.vec_a_x;
        pt_y_q <= in_w.vec_a_y;
        pt_z_q <= in_w.vec_a_z;
      end
    end
    if (cmd_i.load) begin
      m_data_q <= out_w;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/aabb_point_collision_table.sv =====
// Table of axis-aligned boxes with point hit queries.
// Input words arrive on the s_axis channel: tuser carries the action (write entry,
// overlap query, slide query) and tdata carries the entry index, two vectors, the
// kit code, the solid flag and the frame window. Each word yields one result word on
// m_axis. The box_count register is written through cfg_we_i/cfg_wdata_i; the user must
// write it only while the block is idle (not enforced by the block). It sets how many
// table entries a query walks (at most 64). The table is one single-port-write RAM
// with a registered read; a query reads one entry per cycle and compares it in the
// following cycle. A write word or an unused action goes from acceptance to StDone; a
// query first walks the table in StWalk. StDone loads the result into the output
// register once it is free, and the next word is taken once the result is handed to
// the output register. While the receiver stalls, the result word holds in the output
// register; the block still accepts one more word and finishes it, then waits until
// the register frees. Reset clears the control state, box_count and the latched kit
// code; table entries hold no defined value until they are written.
`timescale 1ns / 1ps
`default_nettype none

module aabb_point_collision_table (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // entry_index, vec_a_x, vec_a_y, vec_a_z, vec_b_x, vec_b_y, vec_b_z, kit_code,
  // solid_flag, frame_low, frame_high, zero pad.
  input  wire logic [aabb_pkg::InWordW-1:0]     s_axis_tdata,
  // action.
  input  wire logic [aabb_pkg::ActionW-1:0]     s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // hit_count, entered_kit, blocked, pos_x, pos_y, pos_z.
  output logic [aabb_pkg::OutWordW-1:0]         m_axis_tdata,
  input  wire logic                             cfg_we_i,
  input  wire logic [aabb_pkg::CountW-1:0]      cfg_wdata_i
);
  import aabb_pkg::*;

  cmd_t    cmd;
  status_t status;

  aabb_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  aabb_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import aabb_pkg::*;

  localparam logic [ActionW-1:0] ActUnused = 2'd3;
  localparam logic signed [CoordW-1:0] CoordTop = 32'sh7FFF_FFFF;
  localparam logic signed [CoordW-1:0] CoordBottom = 32'sh8000_0000;
  localparam longint CoordMaxL = longint'(CoordTop);
  localparam longint CoordMinL = longint'(CoordBottom);
  localparam int Span = 1 << 20;
  localparam int HoldCycles = 300;
  localparam int PhaseWords = 75;

  localparam logic signed [CoordW-1:0] PtX = 32'sh0001_0000;
  localparam logic signed [CoordW-1:0] PtY = 32'shFFFE_0000;
  localparam logic signed [CoordW-1:0] PtZ = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic [ActionW-1:0] act;
    in_word_t           w;
  } stim_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InWordW-1:0]  s_axis_tdata = '0;
  logic [ActionW-1:0]  s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutWordW-1:0] m_axis_tdata;
  logic                cfg_we_i = 1'b0;
  logic [CountW-1:0]   cfg_wdata_i = '0;

  stim_t     word_queue[$];
  stim_t     drive_word;
  out_word_t expected_results[$];
  entry_t    box_tbl[MaxBoxes];
  entry_t    box_plan[MaxBoxes];
  logic [KitW-1:0] kit_latch = '0;
  int        box_limit = 0;
  int        words_queued = 0;
  int        words_sent = 0;
  int        err_cnt = 0;
  int        send_idle_pct = 0;
  int        stall_pct = 0;
  bit        rx_hold = 1'b0;
  bit        word_taken = 1'b0;

  always #5 clk_i = ~clk_i;

  aabb_point_collision_table u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  function automatic logic signed [CoordW-1:0] sat_add(logic signed [CoordW-1:0] a,
                                                       logic signed [CoordW-1:0] b);
    logic signed [CoordW:0] s;
    s = a + b;
    if (s[CoordW] != s[CoordW-1]) begin
      return s[CoordW] ? CoordBottom : CoordTop;
    end
    return s[CoordW-1:0];
  endfunction

  function automatic entry_t to_entry(in_word_t w);
    entry_t e;
    e.min_x = w.vec_a_x;
    e.min_y = w.vec_a_y;
    e.min_z = w.vec_a_z;
    e.max_x = w.vec_b_x;
    e.max_y = w.vec_b_y;
    e.max_z = w.vec_b_z;
    e.kit = w.kit_code;
    e.solid = w.solid_flag;
    e.frame_first = w.frame_low;
    e.frame_last = w.frame_high;
    return e;
  endfunction

  function automatic bit box_hit(entry_t e, logic signed [CoordW-1:0] x, y, z,
                                 logic [FrameW-1:0] f);
    return x >= $signed(e.min_x) && x <= $signed(e.max_x) &&
           y >= $signed(e.min_y) && y <= $signed(e.max_y) &&
           z >= $signed(e.min_z) && z <= $signed(e.max_z) &&
           f >= e.frame_first && f <= e.frame_last;
  endfunction

  function automatic out_word_t predict_result(logic [ActionW-1:0] act, in_word_t w);
    out_word_t r;
    logic signed [CoordW-1:0] np [3];
    int lim;
    int i;
    r = '0;
    lim = (box_limit > MaxBoxes) ? MaxBoxes : box_limit;
    case (act)
      ACT_WRITE: begin
        box_tbl[w.entry_index] = to_entry(w);
      end
      ACT_OVERLAP: begin
        kit_latch = '0;
        for (i = 0; i < lim; i++) begin
          if (box_hit(box_tbl[i], w.vec_a_x, w.vec_a_y, w.vec_a_z, w.frame_low)) begin
            kit_latch = box_tbl[i].kit;
            r.hit_count = r.hit_count + 1'b1;
          end
        end
      end
      ACT_SLIDE: begin
        np[0] = sat_add(w.vec_a_x, w.vec_b_x);
        np[1] = sat_add(w.vec_a_y, w.vec_b_y);
        np[2] = sat_add(w.vec_a_z, w.vec_b_z);
        for (i = 0; i < lim; i++) begin
          if (box_tbl[i].solid && box_hit(box_tbl[i], np[0], np[1], np[2], w.frame_low)) begin
            r.blocked = 1'b1;
          end
        end
        r.pos_x = r.blocked ? w.vec_a_x : np[0];
        r.pos_y = r.blocked ? w.vec_a_y : np[1];
        r.pos_z = r.blocked ? w.vec_a_z : np[2];
      end
      default: begin
      end
    endcase
    r.entered_kit = kit_latch;
    return r;
  endfunction

  function automatic logic signed [CoordW-1:0] rand_coord();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 6) return CoordTop;
    if (r < 12) return CoordBottom;
    if (r < 24) return $urandom;
    return CoordW'(int'($urandom_range(2 * Span)) - Span);
  endfunction

  function automatic stim_t make_item(logic [ActionW-1:0] act,
                                      logic signed [CoordW-1:0] ax, ay, az, bx, by, bz,
                                      logic [FrameW-1:0] frame);
    stim_t s;
    s.act = act;
    s.w = '0;
    s.w.entry_index = EntryIdxW'($urandom);
    s.w.vec_a_x = ax;
    s.w.vec_a_y = ay;
    s.w.vec_a_z = az;
    s.w.vec_b_x = bx;
    s.w.vec_b_y = by;
    s.w.vec_b_z = bz;
    s.w.kit_code = KitW'($urandom);
    s.w.solid_flag = 1'($urandom);
    s.w.frame_low = frame;
    s.w.frame_high = FrameW'($urandom);
    return s;
  endfunction

  function automatic stim_t fixed_box(int idx, logic signed [CoordW-1:0] ax, ay, az, bx, by, bz,
                                      logic [KitW-1:0] kit, logic solid,
                                      logic [FrameW-1:0] win_lo, win_hi);
    stim_t s;
    s = make_item(ACT_WRITE, ax, ay, az, bx, by, bz, win_lo);
    s.w.entry_index = EntryIdxW'(idx);
    s.w.kit_code = kit;
    s.w.solid_flag = solid;
    s.w.frame_high = win_hi;
    return s;
  endfunction

  function automatic stim_t make_write(int idx);
    stim_t s;
    logic signed [CoordW-1:0] mn [3];
    logic signed [CoordW-1:0] mx [3];
    logic [FrameW-1:0] win_lo;
    logic [FrameW-1:0] win_hi;
    int unsigned r;
    int k;
    for (k = 0; k < 3; k++) begin
      mn[k] = rand_coord();
      mx[k] = sat_add(mn[k], CoordW'($urandom_range(1 << 19)));
    end
    if ($urandom_range(9) == 0) begin
      k = $urandom_range(2);
      mx[k] = sat_add(mn[k], -CoordW'($urandom_range(4096, 1)));
    end
    r = $urandom_range(99);
    if (r < 70) begin
      win_lo = FrameW'($urandom_range(10));
      win_hi = win_lo + FrameW'($urandom_range(10));
    end else if (r < 80) begin
      win_lo = '0;
      win_hi = '1;
    end else if (r < 90) begin
      win_lo = FrameW'($urandom);
      win_hi = FrameW'($urandom);
    end else begin
      win_lo = FrameW'($urandom_range(20, 1));
      win_hi = FrameW'($urandom_range(win_lo - 1));
    end
    s = make_item(ACT_WRITE, mn[0], mn[1], mn[2], mx[0], mx[1], mx[2], win_lo);
    s.w.entry_index = EntryIdxW'(idx);
    s.w.frame_high = win_hi;
    return s;
  endfunction

  // Most queries aim at a box written earlier: the point, or the end of the slide,
  // lands inside it, often on a face, in a frame within its window.
  function automatic stim_t make_query(logic [ActionW-1:0] act);
    entry_t e;
    logic signed [CoordW-1:0] a [3];
    logic signed [CoordW-1:0] b [3];
    logic signed [CoordW-1:0] lo [3];
    logic signed [CoordW-1:0] hi [3];
    logic [FrameW-1:0] frame;
    longint span;
    longint off;
    longint start;
    int k;
    e = box_plan[$urandom_range(MaxBoxes - 1)];
    lo = '{e.min_x, e.min_y, e.min_z};
    hi = '{e.max_x, e.max_y, e.max_z};
    for (k = 0; k < 3; k++) begin
      a[k] = rand_coord();
      b[k] = rand_coord();
    end
    frame = ($urandom_range(4) == 0) ? FrameW'($urandom) : FrameW'($urandom_range(20));
    if ($urandom_range(99) < 65) begin
      frame = FrameW'($urandom_range(e.frame_first, e.frame_last));
      for (k = 0; k < 3; k++) begin
        span = longint'(hi[k]) - longint'(lo[k]);
        if (span < 0) begin
          off = 0;
        end else begin
          case ($urandom_range(3))
            0: off = 0;
            1: off = span;
            default: off = longint'({$urandom, $urandom} % 64'(span + 1));
          endcase
        end
        a[k] = CoordW'(longint'(lo[k]) + off);
        if (act == ACT_SLIDE) begin
          start = longint'(a[k]) - longint'(b[k]);
          if (start >= CoordMinL && start <= CoordMaxL) begin
            a[k] = CoordW'(start);
          end else begin
            b[k] = '0;
          end
        end
      end
    end
    return make_item(act, a[0], a[1], a[2], b[0], b[1], b[2], frame);
  endfunction

  task automatic queue_word(stim_t s);
    if (s.act == ACT_WRITE) begin
      box_plan[s.w.entry_index] = to_entry(s.w);
    end
    word_queue.push_back(s);
    words_queued++;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (words_sent != words_queued || expected_results.size() != 0);
    repeat (6) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic set_box_count(int n);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= CountW'(n);
    box_limit = n;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic report_mismatch(string what, logic [CoordW-1:0] got, logic [CoordW-1:0] want);
    if (err_cnt < 40) begin
      $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
    err_cnt++;
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || word_taken) begin
      if (word_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drive_word = word_queue.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= drive_word.w;
        s_axis_tuser <= drive_word.act;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !rx_hold && ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    out_word_t got;
    out_word_t want;
    word_taken = rst_ni && s_axis_tvalid && s_axis_tready;
    if (word_taken) begin
      expected_results.push_back(predict_result(s_axis_tuser, in_word_t'(s_axis_tdata)));
      words_sent++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = out_word_t'(m_axis_tdata);
      if (expected_results.size() == 0) begin
        report_mismatch("result word with nothing pending", got.pos_x, '0);
      end else begin
        want = expected_results.pop_front();
        if (got.hit_count !== want.hit_count)
          report_mismatch("hit_count", got.hit_count, want.hit_count);
        if (got.entered_kit !== want.entered_kit)
          report_mismatch("entered_kit", got.entered_kit, want.entered_kit);
        if (got.blocked !== want.blocked)
          report_mismatch("blocked", got.blocked, want.blocked);
        if (got.pos_x !== want.pos_x)
          report_mismatch("pos_x", got.pos_x, want.pos_x);
        if (got.pos_y !== want.pos_y)
          report_mismatch("pos_y", got.pos_y, want.pos_y);
        if (got.pos_z !== want.pos_z)
          report_mismatch("pos_z", got.pos_z, want.pos_z);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int phase_count [8];
    int ph;
    int n;
    int idx;
    int unsigned r;
    phase_count = '{64, 127, 37, 1, 65, 0, 0, 64};
    phase_count[6] = $urandom_range(63, 2);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    @(posedge clk_i);

    // With an empty walk no entry is read, so the table may still be unwritten.
    queue_word(make_item(ACT_OVERLAP, '0, '0, '0, rand_coord(), rand_coord(), rand_coord(), '0));
    queue_word(make_item(ACT_SLIDE, CoordTop, CoordTop, CoordTop,
                         CoordTop, CoordTop, CoordTop, '0));
    queue_word(make_item(ACT_SLIDE, CoordBottom, CoordBottom, CoordBottom,
                         CoordBottom, CoordBottom, CoordBottom, '1));
    queue_word(make_item(ActUnused, rand_coord(), rand_coord(), rand_coord(),
                         rand_coord(), rand_coord(), rand_coord(), FrameW'($urandom)));

    for (idx = 0; idx < MaxBoxes; idx++) begin
      queue_word(make_write(idx));
    end
    queue_word(fixed_box(0, CoordBottom, CoordBottom, CoordBottom, CoordTop, CoordTop, CoordTop,
                         8'h11, 1'b0, '0, '1));
    queue_word(fixed_box(1, 32'sd100, -32'sd10, -32'sd10, 32'sd99, 32'sd10, 32'sd10,
                         8'h22, 1'b1, '0, '1));
    queue_word(fixed_box(2, '0, '0, '0, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000,
                         8'h33, 1'b1, 16'd10, 16'd5));
    queue_word(fixed_box(3, PtX, PtY, PtZ, PtX, PtY, PtZ, 8'hFF, 1'b1, 16'd7, 16'd7));
    queue_word(fixed_box(62, CoordBottom, CoordBottom, CoordBottom,
                         32'sh8000_FFFF, 32'sh8000_FFFF, 32'sh8000_FFFF, 8'h5A, 1'b1, '0, '1));
    queue_word(fixed_box(63, 32'sh7FFF_0000, 32'sh7FFF_0000, 32'sh7FFF_0000,
                         CoordTop, CoordTop, CoordTop, 8'hC3, 1'b1, '0, '1));

    set_box_count(127);
    queue_word(make_item(ACT_OVERLAP, PtX, PtY, PtZ, '0, '0, '0, 16'd7));
    queue_word(make_item(ACT_OVERLAP, PtX, PtY, PtZ, '0, '0, '0, 16'd8));
    queue_word(make_item(ACT_SLIDE, PtX, PtY, PtZ - 1, '0, '0, 32'sd1, 16'd7));
    queue_word(make_item(ACT_SLIDE, PtX, PtY, PtZ - 1, '0, '0, 32'sd1, 16'd6));
    queue_word(make_item(ACT_SLIDE, CoordTop, CoordTop, CoordTop,
                         CoordTop, CoordTop, CoordTop, '0));
    queue_word(make_item(ACT_SLIDE, CoordBottom, CoordBottom, CoordBottom,
                         CoordBottom, CoordBottom, CoordBottom, '1));
    queue_word(make_item(ACT_OVERLAP, 32'sh8000, 32'sh8000, 32'sh8000, '0, '0, '0, 16'd7));
    queue_word(make_item(ACT_OVERLAP, 32'sd100, '0, '0, '0, '0, '0, '0));
    queue_word(make_item(ACT_OVERLAP, CoordTop, CoordTop, CoordTop, '0, '0, '0, '1));
    queue_word(make_item(ACT_OVERLAP, CoordBottom, CoordBottom, CoordBottom, '0, '0, '0, '0));
    queue_word(make_item(ActUnused, PtX, PtY, PtZ, '0, '0, '0, 16'd7));

    set_box_count(1);
    queue_word(make_item(ACT_OVERLAP, PtX, PtY, PtZ, '0, '0, '0, 16'd7));
    queue_word(make_item(ACT_SLIDE, CoordTop, CoordTop, CoordTop,
                         CoordTop, CoordTop, CoordTop, '0));

    for (ph = 0; ph < 8; ph++) begin
      set_box_count(phase_count[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 57; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 57; end
        default: begin send_idle_pct = 27; stall_pct = 27; end
      endcase
      for (n = 0; n < PhaseWords; n++) begin
        r = $urandom_range(99);
        if (r < 25) begin
          queue_word(make_write($urandom_range(MaxBoxes - 1)));
        end else if (r < 60) begin
          queue_word(make_query(ACT_OVERLAP));
        end else if (r < 95) begin
          queue_word(make_query(ACT_SLIDE));
        end else begin
          queue_word(make_query(ActUnused));
        end
      end
      if (ph % 4 == 0) begin
        // Hold the result channel while words keep coming so the input backs up.
        rx_hold = 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        rx_hold = 1'b0;
      end
    end

    wait_drained();
    repeat (20) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== aabb_point_collision_table.f =====
hw/rtl/aabb_pkg.sv
hw/rtl/aabb_ram.sv
hw/rtl/aabb_ctrl.sv
hw/rtl/aabb_dp.sv
hw/rtl/aabb_point_collision_table.sv
dv/tb_top.sv
